FILE: rtl/core/pccc_pkg.sv
// Shared types, codes and the byte-wise CRC-32 step for the PNG chunk CRC checker.
// No dependencies; every other file in rtl/core imports this package.
package pccc_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISMATCH   = 2'd1;
    localparam logic [1:0] ST_TRUNC_LEN  = 2'd2;
    localparam logic [1:0] ST_TRUNC_BODY = 2'd3;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Work codes passed from the parser to the execution side.
    typedef enum logic [2:0] {
        OP_LEN      = 3'd0,
        OP_TYPE     = 3'd1,
        OP_DATA     = 3'd2,
        OP_CRC      = 3'd3,
        OP_CRC_LAST = 3'd4,
        OP_END_LEN  = 3'd5,
        OP_END_BODY = 3'd6
    } op_t;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        logic [31:0] computed_crc;
        logic [31:0] trailer_crc;
        logic [1:0]  length_bytes_seen;
    } result_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic [1:0] seen;
    } cmd_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic op_has_result(input op_t op);
        return (op == OP_CRC_LAST) || (op == OP_END_LEN) || (op == OP_END_BODY);
    endfunction

endpackage

FILE: rtl/core/pccc_front.sv
// Chunk parser: tracks the field position of each incoming beat and tags it with a work code.
// Depends on pccc_pkg.
module pccc_front
    import pccc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_DATA = 4'b0100,
        PH_CRC  = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  index_reg, index_next;
    logic [23:0] len_lo_reg, len_lo_next;
    logic [31:0] remain_reg, remain_next;
    op_t         op;
    logic        accept;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign accept    = s_valid && cmd_ready;

    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        len_lo_next = len_lo_reg;
        remain_next = remain_reg;
        op          = OP_DATA;
        if (s_data.action == ACT_END) begin
            op          = (phase_reg == PH_LEN) ? OP_END_LEN : OP_END_BODY;
            phase_next  = PH_LEN;
            index_next  = 2'd0;
            len_lo_next = 24'd0;
            remain_next = 32'd0;
        end else begin
            unique case (phase_reg)
                PH_LEN: begin
                    op          = OP_LEN;
                    len_lo_next = {len_lo_reg[15:0], s_data.data_byte};
                    index_next  = index_reg + 2'd1;
                    if (index_reg == 2'd3) begin
                        remain_next = {len_lo_reg, s_data.data_byte};
                        phase_next  = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    op         = OP_TYPE;
                    index_next = index_reg + 2'd1;
                    if (index_reg == 2'd3) begin
                        phase_next = (remain_reg == 32'd0) ? PH_CRC : PH_DATA;
                    end
                end
                PH_DATA: begin
                    op          = OP_DATA;
                    remain_next = remain_reg - 32'd1;
                    if (remain_reg == 32'd1) begin
                        phase_next = PH_CRC;
                        index_next = 2'd0;
                    end
                end
                PH_CRC: begin
                    index_next = index_reg + 2'd1;
                    if (index_reg == 2'd3) begin
                        op          = OP_CRC_LAST;
                        phase_next  = PH_LEN;
                        len_lo_next = 24'd0;
                        remain_next = 32'd0;
                    end else begin
                        op = OP_CRC;
                    end
                end
                default: begin
                    op         = OP_DATA;
                    phase_next = PH_LEN;
                    index_next = 2'd0;
                end
            endcase
        end
    end

    assign cmd.op        = op;
    assign cmd.data_byte = s_data.data_byte;
    assign cmd.seen      = index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_LEN;
            index_reg  <= 2'd0;
            len_lo_reg <= 24'd0;
            remain_reg <= 32'd0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            len_lo_reg <= len_lo_next;
            remain_reg <= remain_next;
        end
    end

endmodule

FILE: rtl/core/pccc_queue.sv
// Short first-in first-out queue of tagged beats between parser and execution side.
// Depends on pccc_pkg.
module pccc_queue
    import pccc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign wr_ready = (count_reg != FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = slot_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wptr_reg <= (wptr_reg == LAST) ? '0 : wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == LAST) ? '0 : rptr_reg + PW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/pccc_back.sv
// Execution side: captures fields, runs the CRC-32 and holds the result register.
// Depends on pccc_pkg.
module pccc_back
    import pccc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    logic [31:0] length_reg, length_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] trailer_reg, trailer_next;
    logic        out_valid_reg;
    result_t     out_reg, res;
    logic        room, take, emit;
    logic [31:0] crc_final, trailer_full;

    assign room      = !out_valid_reg || m_ready;
    assign cmd_ready = !op_has_result(cmd.op) || room;
    assign take      = cmd_valid && cmd_ready;
    assign emit      = take && op_has_result(cmd.op);

    assign crc_final    = ~crc_reg;
    assign trailer_full = {trailer_reg[23:0], cmd.data_byte};

    always_comb begin
        length_next  = length_reg;
        type_next    = type_reg;
        crc_next     = crc_reg;
        trailer_next = trailer_reg;
        res          = '0;
        unique case (cmd.op)
            OP_LEN:  length_next = {length_reg[23:0], cmd.data_byte};
            OP_TYPE: begin
                type_next = {type_reg[23:0], cmd.data_byte};
                crc_next  = crc_byte(crc_reg, cmd.data_byte);
            end
            OP_DATA: crc_next = crc_byte(crc_reg, cmd.data_byte);
            OP_CRC:  trailer_next = trailer_full;
            OP_CRC_LAST: begin
                res.status       = (crc_final == trailer_full) ? ST_OK : ST_MISMATCH;
                res.chunk_type   = type_reg;
                res.chunk_length = length_reg;
                res.computed_crc = crc_final;
                res.trailer_crc  = trailer_full;
            end
            OP_END_LEN: begin
                res.status            = ST_TRUNC_LEN;
                res.length_bytes_seen = cmd.seen;
            end
            OP_END_BODY: begin
                res.status       = ST_TRUNC_BODY;
                res.chunk_type   = type_reg;
                res.chunk_length = length_reg;
            end
            default: res = '0;
        endcase
        // Start the next chunk from a clean slate after any result.
        if (op_has_result(cmd.op)) begin
            length_next  = 32'd0;
            type_next    = 32'd0;
            crc_next     = CRC_INIT;
            trailer_next = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg    <= 32'd0;
            type_reg      <= 32'd0;
            crc_reg       <= CRC_INIT;
            trailer_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                length_reg  <= length_next;
                type_reg    <= type_next;
                crc_reg     <= crc_next;
                trailer_reg <= trailer_next;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

FILE: rtl/core/png_chunk_crc_checker.sv
// PNG chunk CRC checker: top level joining parser, beat queue and execution side.
// Depends on pccc_pkg, pccc_front, pccc_queue and pccc_back.
//
// Usage:
//   s_valid/s_ready/s_data carry one beat per handshake: a stream byte
//   (action 0) or an end-of-input marker (action 1). m_valid/m_ready/m_data
//   carry one result per completed chunk (after its last CRC byte) and one
//   per end-of-input marker, giving the type, length, both CRCs and status.
//   Throughput: one beat per cycle, sustained while no result waits on a low
//   m_ready, set by the byte-wide CRC-32 step in the execution side; the parser
//   tags each beat in the cycle it is accepted.
//   Result path: a reporting beat is written into the queue, and the result
//   register and m_valid load at the edge where the beat leaves the queue
//   into the execution side.
//   Stalls: while m_ready is low a pending result is held in the output
//   register; non-reporting beats keep flowing. The next reporting beat
//   waits at the head of the queue, the remaining QDEPTH-1 entries fill behind
//   it and then s_ready drops.
//   Reset: synchronous, active low on aresetn; empties the queue, drops any
//   held result and returns the parser to wait for a length field.
module png_chunk_crc_checker
    import pccc_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_data
);

    // Tagged beats from the parser into the queue.
    logic fq_valid, fq_ready;
    cmd_t fq_cmd;
    // Tagged beats from the queue into the execution side.
    logic qb_valid, qb_ready;
    cmd_t qb_cmd;

    pccc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    // Decouple the parser from result back-pressure.
    pccc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_cmd   (qb_cmd)
    );

    pccc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
